>>> hw/rtl/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared types and constants of the Gillespie reaction step core.
// ----------------------------------------------------------------------------
package gsr_pkg;

  localparam int unsigned RATE_W    = 32;
  localparam int unsigned TIME_W    = 64;
  localparam int unsigned PROP_W    = 61;
  localparam int unsigned NUM_RX    = 7;
  localparam int unsigned NUM_SP    = 6;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned IDX_W     = 3;
  localparam int unsigned CNT_W     = 7;
  localparam int unsigned SQ_ITERS  = 32;
  localparam int unsigned DIV_ITERS = 64;
  localparam int unsigned PAIR      = 2;

  localparam logic [31:0]       LN2_Q32  = 32'hB172_17F7;
  localparam logic [PROP_W-1:0] PROP_MAX = '1;

  // species slots
  localparam int unsigned SP_A  = 0;
  localparam int unsigned SP_FV = 1;
  localparam int unsigned SP_AF = 2;
  localparam int unsigned SP_SV = 3;
  localparam int unsigned SP_AS = 4;
  localparam int unsigned SP_A2 = 5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_A_FV_BIND  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_AF_RELEASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_A_SV_BIND  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_A_AS       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_AF_SV      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_AF_AS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_AF_AF      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_TIME       = 3'd7;

  // propensity slot of each reaction
  localparam logic [IDX_W-1:0] PI_A_FV_BIND  = 3'd0;
  localparam logic [IDX_W-1:0] PI_AF_RELEASE = 3'd1;
  localparam logic [IDX_W-1:0] PI_A_SV_BIND  = 3'd2;
  localparam logic [IDX_W-1:0] PI_A_AS       = 3'd3;
  localparam logic [IDX_W-1:0] PI_AF_SV      = 3'd4;
  localparam logic [IDX_W-1:0] PI_AF_AS      = 3'd5;
  localparam logic [IDX_W-1:0] PI_AF_AF      = 3'd6;

  // fired codes
  localparam logic [2:0] RX_NONE       = 3'd0;
  localparam logic [2:0] RX_A_FV_BIND  = 3'd1;
  localparam logic [2:0] RX_AF_RELEASE = 3'd2;
  localparam logic [2:0] RX_A_SV_BIND  = 3'd3;
  localparam logic [2:0] RX_A_AS       = 3'd4;
  localparam logic [2:0] RX_AF_SV      = 3'd5;
  localparam logic [2:0] RX_AF_AS      = 3'd6;
  localparam logic [2:0] RX_AF_AF      = 3'd7;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_LOAD,
    DP_SET_DONE,
    DP_PM1,
    DP_PM2,
    DP_PM3,
    DP_PSAT,
    DP_PADD,
    DP_LOG_INIT,
    DP_NORM,
    DP_SQ,
    DP_L2,
    DP_LN1,
    DP_LN2,
    DP_DIV_INIT,
    DP_DIV,
    DP_TADD,
    DP_C1,
    DP_C2,
    DP_C3,
    DP_PICK,
    DP_APPLY,
    DP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic is_step;
    logic done;
    logic time_ge_stop;
    logic time_gt_stop;
    logic total_zero;
    logic norm_ok;
    logic pick_hit;
  } dp_sts_t;

endpackage

>>> hw/rtl/gsr_dp.sv
// ----------------------------------------------------------------------------
// gsr_dp
// Datapath: state, configuration, shared 32x32 multiplier, log iteration,
// restoring divider and reaction update.
// ----------------------------------------------------------------------------
module gsr_dp #(
  parameter int unsigned COUNT_BITS   = 16,
  parameter int unsigned UNIFORM_BITS = 24
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gsr_pkg::dp_cmd_t                cmd,
  output gsr_pkg::dp_sts_t                sts,
  input  logic                            in_op,
  input  logic [UNIFORM_BITS-1:0]         in_u_time,
  input  logic [UNIFORM_BITS-1:0]         in_u_choice,
  input  logic [COUNT_BITS-1:0]           in_load_a,
  input  logic [COUNT_BITS-1:0]           in_load_fv,
  input  logic [COUNT_BITS-1:0]           in_load_af,
  input  logic [COUNT_BITS-1:0]           in_load_sv,
  input  logic [COUNT_BITS-1:0]           in_load_as,
  input  logic [COUNT_BITS-1:0]           in_load_a2,
  input  logic                            cfg_we,
  input  logic [gsr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [gsr_pkg::TIME_W-1:0]      cfg_data,
  output logic [gsr_pkg::TIME_W-1:0]      out_sim_time,
  output logic [COUNT_BITS-1:0]           out_a,
  output logic [COUNT_BITS-1:0]           out_fv,
  output logic [COUNT_BITS-1:0]           out_af,
  output logic [COUNT_BITS-1:0]           out_sv,
  output logic [COUNT_BITS-1:0]           out_as,
  output logic [COUNT_BITS-1:0]           out_a2,
  output logic [2:0]                      out_fired,
  output logic                            out_finished
);
  import gsr_pkg::*;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v,
                                                    input logic [1:0] n);
    logic [COUNT_BITS:0] s;
    s = {1'b0, v} + (COUNT_BITS+1)'(n);
    return s[COUNT_BITS] ? '1 : s[COUNT_BITS-1:0];
  endfunction

  logic [RATE_W-1:0]     rate_r [NUM_RX];
  logic [TIME_W-1:0]     stop_r;
  logic [TIME_W-1:0]     time_r;
  logic [COUNT_BITS-1:0] cnt_r [NUM_SP];
  logic                  done_r;

  logic                    op_r;
  logic [UNIFORM_BITS-1:0] ut_r;
  logic [UNIFORM_BITS-1:0] uc_r;
  logic [COUNT_BITS-1:0]   ld_r [NUM_SP];

  logic [PROP_W-1:0] prop_r [NUM_RX];
  logic [TIME_W-1:0] total_r;
  logic [PROP_W-1:0] a_r;
  logic [63:0]       lo_r;
  logic [63:0]       hi_r;
  logic [32:0]       x_r;
  logic [4:0]        nsh_r;
  logic              rsh_r;
  logic [31:0]       frac_r;
  logic [37:0]       l2_r;
  logic [31:0]       t_r;
  logic [39:0]       lnv_r;
  logic [63:0]       num_r;
  logic [63:0]       rem_r;
  logic [63:0]       target_r;
  logic [63:0]       cum_r;
  logic [2:0]        pick_r;
  logic [2:0]        fired_r;

  logic [31:0]       c1, c2, ma, mb;
  logic [63:0]       prod;
  logic [95:0]       sum96;
  logic [PROP_W-1:0] p1sat, psat;
  logic [32:0]       sq_y;
  logic [5:0]        ip;
  logic [64:0]       r2, dsub;
  logic [64:0]       tsum;
  logic [63:0]       cum_nxt;
  logic [COUNT_BITS-1:0] nc [NUM_SP];
  logic              apply_ok;

  always_comb begin
    c1 = '0;
    c2 = '0;
    case (cmd.idx)
      PI_A_FV_BIND:  begin c1 = 32'(cnt_r[SP_A]);  c2 = 32'(cnt_r[SP_FV]); end
      PI_AF_RELEASE: begin c1 = 32'(cnt_r[SP_AF]); c2 = 32'd1; end
      PI_A_SV_BIND:  begin c1 = 32'(cnt_r[SP_A]);  c2 = 32'(cnt_r[SP_SV]); end
      PI_A_AS:       begin c1 = 32'(cnt_r[SP_A]);  c2 = 32'(cnt_r[SP_AS]); end
      PI_AF_SV:      begin c1 = 32'(cnt_r[SP_AF]); c2 = 32'(cnt_r[SP_SV]); end
      PI_AF_AS:      begin c1 = 32'(cnt_r[SP_AF]); c2 = 32'(cnt_r[SP_AS]); end
      PI_AF_AF: begin
        c1 = (cnt_r[SP_AF] >= COUNT_BITS'(PAIR)) ? 32'(cnt_r[SP_AF]) : 32'd0;
        c2 = 32'(cnt_r[SP_AF]);
      end
      default: begin c1 = '0; c2 = '0; end
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      DP_PM1: begin ma = rate_r[cmd.idx];        mb = c1; end
      DP_PM2: begin ma = a_r[31:0];              mb = c2; end
      DP_PM3: begin ma = 32'(a_r[PROP_W-1:32]);  mb = c2; end
      DP_SQ:  begin ma = x_r[31:0];              mb = x_r[31:0]; end
      DP_LN1: begin ma = l2_r[31:0];             mb = LN2_Q32; end
      DP_LN2: begin ma = 32'(l2_r[37:32]);       mb = LN2_Q32; end
      DP_C1:  begin ma = 32'(uc_r);              mb = total_r[31:0]; end
      DP_C2:  begin ma = 32'(uc_r);              mb = total_r[63:32]; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod    = 64'(ma) * 64'(mb);
  assign sum96   = {32'd0, lo_r} + {hi_r, 32'd0};
  assign p1sat   = (|prod[63:PROP_W]) ? PROP_MAX : prod[PROP_W-1:0];
  assign psat    = (|sum96[95:PROP_W]) ? PROP_MAX : sum96[PROP_W-1:0];
  assign sq_y    = prod[63:31];
  assign ip      = 6'(7'(UNIFORM_BITS) + 7'(nsh_r) - 7'd31 - 7'(rsh_r));
  assign r2      = {rem_r, num_r[63]};
  assign dsub    = r2 - {1'b0, total_r};
  assign tsum    = {1'b0, time_r} + {1'b0, num_r};
  assign cum_nxt = cum_r + 64'(prop_r[cmd.idx]);

  always_comb begin
    nc = cnt_r;
    apply_ok = 1'b0;
    case (pick_r)
      RX_A_FV_BIND: if (cnt_r[SP_A] != '0 && cnt_r[SP_FV] != '0) begin
        apply_ok = 1'b1;
        nc[SP_A]  = cnt_r[SP_A] - 1'b1;
        nc[SP_FV] = cnt_r[SP_FV] - 1'b1;
        nc[SP_AF] = sat_inc(cnt_r[SP_AF], 2'd1);
      end
      RX_AF_RELEASE: if (cnt_r[SP_AF] != '0) begin
        apply_ok = 1'b1;
        nc[SP_AF] = cnt_r[SP_AF] - 1'b1;
        nc[SP_A]  = sat_inc(cnt_r[SP_A], 2'd1);
        nc[SP_FV] = sat_inc(cnt_r[SP_FV], 2'd1);
      end
      RX_A_SV_BIND: if (cnt_r[SP_A] != '0 && cnt_r[SP_SV] != '0) begin
        apply_ok = 1'b1;
        nc[SP_A]  = cnt_r[SP_A] - 1'b1;
        nc[SP_SV] = cnt_r[SP_SV] - 1'b1;
        nc[SP_AS] = sat_inc(cnt_r[SP_AS], 2'd1);
      end
      RX_A_AS: if (cnt_r[SP_A] != '0 && cnt_r[SP_AS] != '0) begin
        apply_ok = 1'b1;
        nc[SP_A]  = cnt_r[SP_A] - 1'b1;
        nc[SP_AS] = cnt_r[SP_AS] - 1'b1;
        nc[SP_A2] = sat_inc(cnt_r[SP_A2], 2'd1);
        nc[SP_SV] = sat_inc(cnt_r[SP_SV], 2'd1);
      end
      RX_AF_SV: if (cnt_r[SP_AF] != '0 && cnt_r[SP_SV] != '0) begin
        apply_ok = 1'b1;
        nc[SP_AF] = cnt_r[SP_AF] - 1'b1;
        nc[SP_SV] = cnt_r[SP_SV] - 1'b1;
        nc[SP_FV] = sat_inc(cnt_r[SP_FV], 2'd1);
        nc[SP_AS] = sat_inc(cnt_r[SP_AS], 2'd1);
      end
      RX_AF_AS: if (cnt_r[SP_AF] != '0 && cnt_r[SP_AS] != '0) begin
        apply_ok = 1'b1;
        nc[SP_AF] = cnt_r[SP_AF] - 1'b1;
        nc[SP_AS] = cnt_r[SP_AS] - 1'b1;
        nc[SP_A2] = sat_inc(cnt_r[SP_A2], 2'd1);
        nc[SP_SV] = sat_inc(cnt_r[SP_SV], 2'd1);
        nc[SP_FV] = sat_inc(cnt_r[SP_FV], 2'd1);
      end
      RX_AF_AF: if (cnt_r[SP_AF] >= COUNT_BITS'(PAIR)) begin
        apply_ok = 1'b1;
        nc[SP_AF] = cnt_r[SP_AF] - COUNT_BITS'(PAIR);
        nc[SP_A2] = sat_inc(cnt_r[SP_A2], 2'd1);
        nc[SP_FV] = sat_inc(cnt_r[SP_FV], 2'(PAIR));
      end
      default: apply_ok = 1'b0;
    endcase
  end

  // architectural state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_RX; i++) rate_r[i] <= '0;
      for (int i = 0; i < NUM_SP; i++) cnt_r[i] <= '0;
      stop_r <= '0;
      time_r <= '0;
      done_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_STOP_TIME) begin
          stop_r <= cfg_data;
        end else begin
          for (int i = 0; i < NUM_RX; i++) begin
            if (cfg_index == CFG_IDX_W'(i)) rate_r[i] <= cfg_data[RATE_W-1:0];
          end
        end
      end
      case (cmd.op)
        DP_LOAD: begin
          cnt_r  <= ld_r;
          time_r <= '0;
          done_r <= 1'b0;
        end
        DP_SET_DONE: done_r <= 1'b1;
        DP_TADD:     time_r <= tsum[64] ? '1 : tsum[63:0];
        DP_APPLY:    cnt_r  <= nc;
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_CAPTURE: begin
        op_r           <= in_op;
        ut_r           <= in_u_time;
        uc_r           <= in_u_choice;
        ld_r[SP_A]     <= in_load_a;
        ld_r[SP_FV]    <= in_load_fv;
        ld_r[SP_AF]    <= in_load_af;
        ld_r[SP_SV]    <= in_load_sv;
        ld_r[SP_AS]    <= in_load_as;
        ld_r[SP_A2]    <= in_load_a2;
        total_r        <= '0;
        cum_r          <= '0;
        pick_r         <= RX_NONE;
        fired_r        <= RX_NONE;
      end
      DP_PM1:  a_r  <= p1sat;
      DP_PM2:  lo_r <= prod;
      DP_PM3:  hi_r <= prod;
      DP_PSAT: prop_r[cmd.idx] <= psat;
      DP_PADD: total_r <= total_r + 64'(prop_r[cmd.idx]);
      DP_LOG_INIT: begin
        x_r    <= 33'(ut_r) + 33'd1;
        nsh_r  <= '0;
        rsh_r  <= 1'b0;
        frac_r <= '0;
      end
      DP_NORM: begin
        if (x_r[32]) begin
          x_r   <= x_r >> 1;
          rsh_r <= 1'b1;
        end else begin
          x_r   <= x_r << 1;
          nsh_r <= nsh_r + 5'd1;
        end
      end
      DP_SQ: begin
        frac_r <= {frac_r[30:0], sq_y[32]};
        x_r    <= sq_y[32] ? {1'b0, sq_y[32:1]} : {1'b0, sq_y[31:0]};
      end
      DP_L2:  l2_r  <= (38'(ip) << 32) - 38'(frac_r);
      DP_LN1: t_r   <= prod[63:32];
      DP_LN2: lnv_r <= 40'(prod) + 40'(t_r);
      DP_DIV_INIT: begin
        num_r <= 64'(lnv_r) << 16;
        rem_r <= '0;
      end
      DP_DIV: begin
        rem_r <= dsub[64] ? r2[63:0] : dsub[63:0];
        num_r <= {num_r[62:0], ~dsub[64]};
      end
      DP_C1: lo_r <= prod;
      DP_C2: hi_r <= prod;
      DP_C3: target_r <= sum96[UNIFORM_BITS+63:UNIFORM_BITS];
      DP_PICK: begin
        cum_r <= cum_nxt;
        if (cum_nxt > target_r) pick_r <= cmd.idx + 3'd1;
      end
      DP_APPLY: fired_r <= apply_ok ? pick_r : RX_NONE;
      DP_OUT: begin
        out_sim_time <= time_r;
        out_a        <= cnt_r[SP_A];
        out_fv       <= cnt_r[SP_FV];
        out_af       <= cnt_r[SP_AF];
        out_sv       <= cnt_r[SP_SV];
        out_as       <= cnt_r[SP_AS];
        out_a2       <= cnt_r[SP_A2];
        out_fired    <= fired_r;
        out_finished <= done_r;
      end
      default: ;
    endcase
  end

  assign sts.is_step      = op_r;
  assign sts.done         = done_r;
  assign sts.time_ge_stop = (time_r >= stop_r);
  assign sts.time_gt_stop = (time_r > stop_r);
  assign sts.total_zero   = (total_r == '0);
  assign sts.norm_ok      = ~x_r[32] & x_r[31];
  assign sts.pick_hit     = (cum_nxt > target_r);

endmodule

>>> hw/rtl/gsr_ctrl.sv
// ----------------------------------------------------------------------------
// gsr_ctrl
// Sequencer: handshakes, loop counters and datapath commands for one item.
// ----------------------------------------------------------------------------
module gsr_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output gsr_pkg::dp_cmd_t cmd,
  input  gsr_pkg::dp_sts_t sts
);
  import gsr_pkg::*;

  typedef enum logic [22:0] {
    S_IDLE  = 23'd1 << 0,
    S_CHECK = 23'd1 << 1,
    S_PM1   = 23'd1 << 2,
    S_PM2   = 23'd1 << 3,
    S_PM3   = 23'd1 << 4,
    S_PSAT  = 23'd1 << 5,
    S_PADD  = 23'd1 << 6,
    S_ZCHK  = 23'd1 << 7,
    S_NORM  = 23'd1 << 8,
    S_SQ    = 23'd1 << 9,
    S_L2    = 23'd1 << 10,
    S_LN1   = 23'd1 << 11,
    S_LN2   = 23'd1 << 12,
    S_DIVI  = 23'd1 << 13,
    S_DIV   = 23'd1 << 14,
    S_TADD  = 23'd1 << 15,
    S_TCHK  = 23'd1 << 16,
    S_C1    = 23'd1 << 17,
    S_C2    = 23'd1 << 18,
    S_C3    = 23'd1 << 19,
    S_PICK  = 23'd1 << 20,
    S_APPLY = 23'd1 << 21,
    S_OUT   = 23'd1 << 22
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd.op        = DP_NOP;
    cmd.idx       = cnt_r[IDX_W-1:0];
    out_valid_nxt = out_valid_r & out_stall;
    case (state_r)
      S_IDLE: if (in_valid) begin
        cmd.op    = DP_CAPTURE;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        cnt_nxt = '0;
        if (!sts.is_step) begin
          cmd.op    = DP_LOAD;
          state_nxt = S_OUT;
        end else if (sts.done) begin
          state_nxt = S_OUT;
        end else if (sts.time_ge_stop) begin
          cmd.op    = DP_SET_DONE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_PM1;
        end
      end
      S_PM1:  begin cmd.op = DP_PM1;  state_nxt = S_PM2;  end
      S_PM2:  begin cmd.op = DP_PM2;  state_nxt = S_PM3;  end
      S_PM3:  begin cmd.op = DP_PM3;  state_nxt = S_PSAT; end
      S_PSAT: begin cmd.op = DP_PSAT; state_nxt = S_PADD; end
      S_PADD: begin
        cmd.op = DP_PADD;
        if (cnt_r[IDX_W-1:0] == PI_AF_AF) begin
          cnt_nxt   = '0;
          state_nxt = S_ZCHK;
        end else begin
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = S_PM1;
        end
      end
      S_ZCHK: begin
        if (sts.total_zero) begin
          cmd.op    = DP_SET_DONE;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = DP_LOG_INIT;
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_ok) begin
          cnt_nxt   = '0;
          state_nxt = S_SQ;
        end else begin
          cmd.op = DP_NORM;
        end
      end
      S_SQ: begin
        cmd.op  = DP_SQ;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(SQ_ITERS - 1)) state_nxt = S_L2;
      end
      S_L2:  begin cmd.op = DP_L2;  state_nxt = S_LN1; end
      S_LN1: begin cmd.op = DP_LN1; state_nxt = S_LN2; end
      S_LN2: begin cmd.op = DP_LN2; state_nxt = S_DIVI; end
      S_DIVI: begin
        cmd.op    = DP_DIV_INIT;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.op  = DP_DIV;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(DIV_ITERS - 1)) state_nxt = S_TADD;
      end
      S_TADD: begin cmd.op = DP_TADD; state_nxt = S_TCHK; end
      S_TCHK: begin
        if (sts.time_gt_stop) begin
          cmd.op    = DP_SET_DONE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_C1;
        end
      end
      S_C1: begin cmd.op = DP_C1; state_nxt = S_C2; end
      S_C2: begin cmd.op = DP_C2; state_nxt = S_C3; end
      S_C3: begin
        cmd.op    = DP_C3;
        cnt_nxt   = '0;
        state_nxt = S_PICK;
      end
      S_PICK: begin
        cmd.op  = DP_PICK;
        cnt_nxt = cnt_r + 1'b1;
        if (sts.pick_hit || cnt_r[IDX_W-1:0] == PI_AF_AF) state_nxt = S_APPLY;
      end
      S_APPLY: begin cmd.op = DP_APPLY; state_nxt = S_OUT; end
      S_OUT: if (!out_valid_r || !out_stall) begin
        cmd.op        = DP_OUT;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTH
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_CHECK))
    else $error("accepted item did not start");
  a_load_short: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CHECK && !sts.is_step) |=> (state_r == S_OUT))
    else $error("load item did not go to output");
  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == CNT_W'(DIV_ITERS - 1)) |=> (state_r == S_TADD))
    else $error("divider loop length wrong");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && out_valid_r && out_stall) |=> (state_r == S_OUT && out_valid_r))
    else $error("result overwritten while stalled");
`endif

endmodule

>>> hw/rtl/gillespie_reaction_step_core.sv
// ----------------------------------------------------------------------------
// gillespie_reaction_step_core
// Gillespie direct-method step over a fixed seven-reaction, six-species net.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid/in_stall): in_op 0 loads counts and clears time and
//  the finished flag; in_op 1 runs one step with uniforms in_u_time and
//  in_u_choice. Each item gives exactly one result on the out_ channel.
//  Config channel (cfg_valid/cfg_ready, always ready): index 0..6 writes rate
//  registers (Q16.16), index 7 the stop time (Q32.32). Write only while idle.
//  A load item goes straight from the check to output. A step item computes
//  the seven propensities on the shared 32x32 multiplier, normalizes, runs
//  32 log squarings and a 64-bit restoring divider, then choice and update;
//  an already finished or stop-time-reached step skips all of this, and a
//  zero total rate ends after the propensities.
//  One item is in flight at a time; a new item is taken while the previous
//  result still sits in the output register.
//  Reset clears rates, stop time, time, counts and the finished flag.
//  A stalled result holds; the core waits before overwriting it.
// ----------------------------------------------------------------------------
module gillespie_reaction_step_core #(
  parameter int unsigned COUNT_BITS   = 16,
  parameter int unsigned UNIFORM_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_op,
  input  logic [UNIFORM_BITS-1:0]       in_u_time,
  input  logic [UNIFORM_BITS-1:0]       in_u_choice,
  input  logic [COUNT_BITS-1:0]         in_load_a,
  input  logic [COUNT_BITS-1:0]         in_load_fv,
  input  logic [COUNT_BITS-1:0]         in_load_af,
  input  logic [COUNT_BITS-1:0]         in_load_sv,
  input  logic [COUNT_BITS-1:0]         in_load_as,
  input  logic [COUNT_BITS-1:0]         in_load_a2,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [gsr_pkg::TIME_W-1:0]    out_sim_time,
  output logic [COUNT_BITS-1:0]         out_a,
  output logic [COUNT_BITS-1:0]         out_fv,
  output logic [COUNT_BITS-1:0]         out_af,
  output logic [COUNT_BITS-1:0]         out_sv,
  output logic [COUNT_BITS-1:0]         out_as,
  output logic [COUNT_BITS-1:0]         out_a2,
  output logic [2:0]                    out_fired,
  output logic                          out_finished,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gsr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gsr_pkg::TIME_W-1:0]    cfg_data
);
  import gsr_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  gsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  gsr_dp #(
    .COUNT_BITS   (COUNT_BITS),
    .UNIFORM_BITS (UNIFORM_BITS)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (in_op),
    .in_u_time    (in_u_time),
    .in_u_choice  (in_u_choice),
    .in_load_a    (in_load_a),
    .in_load_fv   (in_load_fv),
    .in_load_af   (in_load_af),
    .in_load_sv   (in_load_sv),
    .in_load_as   (in_load_as),
    .in_load_a2   (in_load_a2),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_sim_time (out_sim_time),
    .out_a        (out_a),
    .out_fv       (out_fv),
    .out_af       (out_af),
    .out_sv       (out_sv),
    .out_as       (out_as),
    .out_a2       (out_a2),
    .out_fired    (out_fired),
    .out_finished (out_finished)
  );

endmodule
